/* hdl/gibs_pkg.sv */
// Shared types and constants for the greedy IoU box suppression block.
// Used by gibs_cell and greedy_iou_box_suppression; depends on nothing.
package gibs_pkg;

  // Box as held in the chain: edges, far edges and area
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [16:0] right;
    logic signed [16:0] bottom;
    logic        [29:0] area;
  } box_t;

  // Store request broadcast to every cell
  typedef struct packed {
    logic en;
    box_t box;
  } write_t;

  // Reset value of the threshold: 0.45 in Q0.16
  localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;

endpackage

/* hdl/gibs_cell.sv */
// One compare cell of the suppression chain: holds one kept box, tests the
// passing box against it and ORs its verdict into the suppress chain.
// Depends on gibs_pkg.
module gibs_cell #(
  parameter int INDEX = 0,
  parameter int KCW   = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  gibs_pkg::box_t    box_in,
  input  logic              box_valid_in,
  output gibs_pkg::box_t    box_out,
  output logic              box_valid_out,
  input  logic              sup_in,
  output logic              sup_out,
  output logic              sup_valid_out,
  input  logic [KCW-1:0]    count,
  input  logic [15:0]       threshold,
  input  gibs_pkg::write_t  wr
);

  gibs_pkg::box_t entry;

  logic signed [16:0] min_right;
  logic signed [16:0] min_bottom;
  logic signed [15:0] max_left;
  logic signed [15:0] max_top;
  logic signed [17:0] diff_w;
  logic signed [17:0] diff_h;
  logic        [14:0] iw_next;
  logic        [14:0] ih_next;

  logic        v1, v2, v3, v4;
  logic        act1, act2, act3, act4;
  logic [14:0] iw1, ih1;
  logic [30:0] sum1, sum2;
  logic [29:0] inter2, inter3, inter4;
  logic [30:0] uni3;
  logic [46:0] prod4;
  logic        hit;

  // Store the kept box when this cell is the next free slot
  always_ff @(posedge clk) begin
    if (wr.en && count == KCW'(INDEX)) begin
      entry <= wr.box;
    end
  end

  // Overlap extent on each axis, clipped at zero
  always_comb begin
    min_right  = (box_in.right < entry.right) ? box_in.right : entry.right;
    min_bottom = (box_in.bottom < entry.bottom) ? box_in.bottom : entry.bottom;
    max_left   = (box_in.left > entry.left) ? box_in.left : entry.left;
    max_top    = (box_in.top > entry.top) ? box_in.top : entry.top;
    diff_w     = {min_right[16], min_right} - {{2{max_left[15]}}, max_left};
    diff_h     = {min_bottom[16], min_bottom} - {{2{max_top[15]}}, max_top};
    iw_next    = (diff_w > 18'sd0) ? diff_w[14:0] : 15'd0;
    ih_next    = (diff_h > 18'sd0) ? diff_h[14:0] : 15'd0;
  end

  // Suppress when intersection * 2^16 exceeds threshold * union
  assign hit = act4 && ({1'b0, inter4, 16'b0} > prod4);

  // Control: pass the box on, advance the stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid_out <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      v4            <= 1'b0;
      sup_valid_out <= 1'b0;
    end else begin
      box_valid_out <= box_valid_in;
      v1            <= box_valid_in;
      v2            <= v1;
      v3            <= v2;
      v4            <= v3;
      sup_valid_out <= v4;
    end
  end

  // Datapath: overlap, intersection, union, scaled union, verdict
  always_ff @(posedge clk) begin
    box_out <= box_in;
    act1    <= (KCW'(INDEX) < count);
    iw1     <= iw_next;
    ih1     <= ih_next;
    sum1    <= {1'b0, box_in.area} + {1'b0, entry.area};
    act2    <= act1;
    inter2  <= iw1 * ih1;
    sum2    <= sum1;
    act3    <= act2;
    inter3  <= inter2;
    uni3    <= sum2 - {1'b0, inter2};
    act4    <= act3;
    inter4  <= inter3;
    prod4   <= threshold * uni3;
    sup_out <= sup_in | hit;
  end

endmodule

/* hdl/greedy_iou_box_suppression.sv */
// Greedy IoU non-maximum suppression over a frame of score-ordered boxes.
// Top level: input capture, frame control and a chain of gibs_cell.
// Depends on gibs_pkg and gibs_cell.
//
//   channel  handshake                payload
//   -------  -----------------------  -------------------------------------
//   in       in_valid / in_stall      box_left box_top box_width box_height
//                                     frame_end
//   out      out_valid / out_stall    kept box_number table_overflow
//                                     frame_done
//   config   cfg_we                   cfg_data (iou_threshold)
//
// One box at a time walks the chain of MAX_KEPT cells, one cell a cycle, and
// each cell takes its compare through the overlap, intersection, union,
// scaled union and verdict registers; the verdict that leaves the last cell
// is taken in RUN and written to the output register in FINISH, and only then
// can the next box be taken, so the time per box is set by the chain length.
// in_stall is high in reset and from a transfer until the result is in the
// output register. The output register holds the result under out_stall
// while the next box runs.
// Synchronous reset empties the table, zeroes the box counter and loads 0.45.
module greedy_iou_box_suppression #(
  parameter int MAX_KEPT  = 64,
  parameter int MAX_BOXES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] box_left,
  input  logic signed [15:0] box_top,
  input  logic        [14:0] box_width,
  input  logic        [14:0] box_height,
  input  logic               frame_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kept,
  output logic        [11:0] box_number,
  output logic               table_overflow,
  output logic               frame_done,
  input  logic               cfg_we,
  input  logic        [15:0] cfg_data
);

  localparam int KCW = $clog2(MAX_KEPT + 1);
  localparam int CW  = $clog2(MAX_BOXES);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    FINISH
  } state_t;

  state_t               state;
  logic [15:0]          threshold;
  logic [KCW-1:0]       kept_count;
  logic [CW-1:0]        box_counter;
  logic [CW+11:0]       counter_wide;
  gibs_pkg::box_t       box;
  logic                 fend;
  logic                 launch;
  logic                 suppress;
  logic                 full;
  logic                 out_free;
  gibs_pkg::write_t     wr;

  gibs_pkg::box_t       box_chain       [MAX_KEPT+1];
  logic                 box_valid_chain [MAX_KEPT+1];
  logic                 sup_chain       [MAX_KEPT+1];
  logic                 sup_valid       [MAX_KEPT];

  assign in_stall     = rst || (state != IDLE);
  assign full         = (kept_count == KCW'(MAX_KEPT));
  assign out_free     = !out_valid || !out_stall;
  assign counter_wide = {12'b0, box_counter};

  // Store a survivor into the next free cell
  always_comb begin
    wr.en  = (state == FINISH) && out_free && !suppress && !full;
    wr.box = box;
  end

  // Feed the head of the chain
  assign box_chain[0]       = box;
  assign box_valid_chain[0] = launch;
  assign sup_chain[0]       = 1'b0;

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    gibs_cell #(
      .INDEX (i),
      .KCW   (KCW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .box_in        (box_chain[i]),
      .box_valid_in  (box_valid_chain[i]),
      .box_out       (box_chain[i+1]),
      .box_valid_out (box_valid_chain[i+1]),
      .sup_in        (sup_chain[i]),
      .sup_out       (sup_chain[i+1]),
      .sup_valid_out (sup_valid[i]),
      .count         (kept_count),
      .threshold     (threshold),
      .wr            (wr)
    );
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= gibs_pkg::IOU_THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  // Frame control, output register and table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      launch      <= 1'b0;
      out_valid   <= 1'b0;
      kept_count  <= '0;
      box_counter <= '0;
    end else begin
      launch <= (state == IDLE) && in_valid;
      if (out_valid && !out_stall && state != FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          // capture the box and its far edges and area
          if (in_valid) begin
            box.left   <= box_left;
            box.top    <= box_top;
            box.right  <= {box_left[15], box_left} + {2'b0, box_width};
            box.bottom <= {box_top[15], box_top} + {2'b0, box_height};
            box.area   <= box_width * box_height;
            fend       <= frame_end;
            state      <= RUN;
          end
        end
        RUN: begin
          // wait for the verdict to leave the last cell
          if (sup_valid[MAX_KEPT-1]) begin
            suppress <= sup_chain[MAX_KEPT];
            state    <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            kept           <= !suppress;
            table_overflow <= !suppress && full;
            frame_done     <= fend;
            box_number     <= counter_wide[11:0];
            if (fend) begin
              kept_count  <= '0;
              box_counter <= '0;
            end else begin
              if (!suppress && !full) begin
                kept_count <= kept_count + KCW'(1);
              end
              if (box_counter == CW'(MAX_BOXES - 1)) begin
                box_counter <= '0;
              end else begin
                box_counter <= box_counter + CW'(1);
              end
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
